### sv/salc_pkg.sv
// Package for the set-associative LRU write-back cache unit.
// Geometry constants, result codes and the per-line record. No dependencies.
package salc_pkg;
  localparam int unsigned Ways = 8;
  localparam int unsigned Sets = 256;
  localparam int unsigned WayW = 3;
  localparam int unsigned SetW = 8;
  localparam int unsigned MaxSetBits = 8;

  typedef enum logic [1:0] {
    KIND_HIT = 2'd0,
    KIND_CLEAN = 2'd1,
    KIND_DIRTY = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    REG_OFFSET = 2'd0,
    REG_SETS = 2'd1,
    REG_WAYS = 2'd2,
    REG_PENALTY = 2'd3
  } reg_e;

  // One line as held in memory. valid lives in its own per-set memory, so not here.
  typedef struct packed {
    logic [31:0] tag;
    logic [47:0] stamp;
    logic [31:0] last_op;
    logic        dirty;
  } line_t;
endpackage

### sv/salc_line_ram.sv
// Line store: one 1R1W synchronous memory holding a full set (all ways) per row.
// Uses salc_pkg for the line record.
module salc_line_ram (
  input  logic                                  clk_i,
  input  logic [salc_pkg::SetW-1:0]             raddr_i,
  output salc_pkg::line_t [salc_pkg::Ways-1:0]  rdata_o,
  input  logic                                  we_i,
  input  logic [salc_pkg::SetW-1:0]             waddr_i,
  input  logic [salc_pkg::WayW-1:0]             wway_i,
  input  salc_pkg::line_t                       wdata_i
);
  import salc_pkg::*;

  line_t mem_q [Sets][Ways];
  line_t [Ways-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i][wway_i] <= wdata_i;
    end
    for (int w = 0; w < Ways; w++) begin
      rd_q[w] <= mem_q[raddr_i][w];
    end
  end

  assign rdata_o = rd_q;
endmodule

### sv/set_assoc_lru_writeback_cache_unit.sv
// Set-associative LRU write-back cache unit (top level).
// Result path: the set is read from the line and valid memories at the accepting edge, and
// the result is registered together with the line write-back.
// Flow: the input stalls until the result is taken and accepts the next item the cycle
// after, so no new item is taken while a result is pending.
// Reset: registers take their reset values, then a pass over all sets clears the valid
// memory one set per cycle with the input stalled.
module set_assoc_lru_writeback_cache_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [31:0] address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  access_kind_o,
  output logic [2:0]  way_o,
  output logic [7:0]  set_index_o,
  output logic [31:0] tag_value_o,
  output logic [31:0] old_tag_o,
  output logic        old_valid_o,
  output logic        old_dirty_o,
  output logic [31:0] prev_op_index_o,
  output logic [31:0] op_index_o,
  output logic [16:0] access_cycles_o
);
  import salc_pkg::*;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_READ, ST_DONE} state_e;

  logic [4:0]  off_bits_q;
  logic [3:0]  set_bits_q, ways_q;
  logic [15:0] penalty_q;
  state_e      state_q;
  logic [SetW-1:0] clr_q;
  logic        is_wr_q;
  logic [SetW-1:0] set_q;
  logic [31:0] tag_q;
  logic [47:0] time_q;
  logic [31:0] opc_q;
  logic [Ways-1:0] vmem_q [Sets];
  logic [Ways-1:0] vrow_q;
  logic        out_valid_q;

  // APB
  logic cfg_we;
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;
  always_comb begin
    case (reg_e'(paddr[3:2]))
      REG_OFFSET:  prdata = {27'd0, off_bits_q};
      REG_SETS:    prdata = {28'd0, set_bits_q};
      REG_WAYS:    prdata = {28'd0, ways_q};
      REG_PENALTY: prdata = {16'd0, penalty_q};
      default:     prdata = '0;
    endcase
  end

  // Address split
  logic [4:0] ob;
  logic [3:0] sb;
  logic [31:0] sh, set_full;
  logic [5:0] tsh;
  assign ob = (off_bits_q > 5'd16) ? 5'd16 : off_bits_q;
  assign sb = (set_bits_q > 4'(MaxSetBits)) ? 4'(MaxSetBits) : set_bits_q;
  assign sh = address_i >> ob;
  assign set_full = sh & ((32'd1 << sb) - 32'd1);
  assign tsh = 6'(ob) + 6'(sb);

  logic accept;
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept = in_valid_i & ~in_stall_o;

  // Lookup on memory read data
  line_t [Ways-1:0] rd;
  logic [Ways-1:0] vrow;
  logic [3:0] nw;
  logic hit, found;
  logic [WayW-1:0] hw, fw, lw, way;
  logic [47:0] best;
  assign nw = (ways_q == 4'd0) ? 4'd1 : ((ways_q > 4'(Ways)) ? 4'(Ways) : ways_q);
  assign vrow = vrow_q;

  always_comb begin
    hit = 1'b0; hw = '0; found = 1'b0; fw = '0;
    best = rd[0].stamp; lw = '0;
    for (int w = Ways - 1; w >= 0; w--) begin
      if (4'(w) < nw) begin
        if (vrow[w] && rd[w].tag == tag_q) begin hit = 1'b1; hw = WayW'(w); end
        if (!vrow[w]) begin found = 1'b1; fw = WayW'(w); end
      end
    end
    for (int w = 1; w < Ways; w++) begin
      if (4'(w) < nw && rd[w].stamp < best) begin best = rd[w].stamp; lw = WayW'(w); end
    end
    way = hit ? hw : (found ? fw : lw);
  end

  line_t sel, wline;
  logic sel_v, sel_dirty;
  kind_e kind;
  logic [16:0] cost;
  logic [47:0] tnext;
  logic [Ways-1:0] vnew;
  assign sel = rd[way];
  assign sel_v = vrow[way];
  assign sel_dirty = sel_v & sel.dirty;
  assign kind = hit ? KIND_HIT : (sel_dirty ? KIND_DIRTY : KIND_CLEAN);
  always_comb begin
    case (kind)
      KIND_HIT:   cost = 17'd1;
      KIND_DIRTY: cost = 17'd1 + {penalty_q, 1'b0};
      default:    cost = 17'd1 + 17'(penalty_q);
    endcase
  end
  assign tnext = time_q + 48'(cost);
  always_comb begin
    wline.tag = hit ? sel.tag : tag_q;
    wline.dirty = hit ? (sel_dirty | is_wr_q) : is_wr_q;
    wline.stamp = tnext;
    wline.last_op = opc_q;
  end
  always_comb begin
    vnew = vrow_q;
    vnew[way] = 1'b1;
  end

  logic do_wr;
  assign do_wr = (state_q == ST_READ);

  salc_line_ram u_ram (
    .clk_i   (clk_i),
    .raddr_i (set_full[SetW-1:0]),
    .rdata_o (rd),
    .we_i    (do_wr),
    .waddr_i (set_q),
    .wway_i  (way),
    .wdata_i (wline)
  );

  // valid row per set, read alongside the line memory; cleared by the pass after reset
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLEAR) begin
      vmem_q[clr_q] <= '0;
    end else if (do_wr) begin
      vmem_q[set_q] <= vnew;
    end
    vrow_q <= vmem_q[set_full[SetW-1:0]];
  end

  // last_op and dirty read as zero on never-valid lines
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_bits_q <= 5'd5; set_bits_q <= 4'd6; ways_q <= 4'd2; penalty_q <= 16'd100;
      state_q <= ST_CLEAR; clr_q <= '0; out_valid_q <= 1'b0; time_q <= '0; opc_q <= '0;
    end else begin
      if (cfg_we) begin
        case (reg_e'(paddr[3:2]))
          REG_OFFSET:  off_bits_q <= pwdata[4:0];
          REG_SETS:    set_bits_q <= pwdata[3:0];
          REG_WAYS:    ways_q <= pwdata[3:0];
          REG_PENALTY: penalty_q <= pwdata[15:0];
          default: ;
        endcase
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == SetW'(Sets - 1)) state_q <= ST_IDLE;
        end
        ST_IDLE: if (accept) state_q <= ST_READ;
        ST_READ: begin
          time_q <= tnext;
          opc_q <= opc_q + 32'd1;
          out_valid_q <= 1'b1;
          state_q <= ST_DONE;
        end
        ST_DONE: if (!out_stall_i) begin out_valid_q <= 1'b0; state_q <= ST_IDLE; end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      is_wr_q <= opcode_i;
      set_q <= set_full[SetW-1:0];
      tag_q <= (tsh >= 6'd32) ? 32'd0 : (address_i >> tsh);
    end
    if (do_wr) begin
      access_kind_o   <= kind;
      way_o           <= way;
      set_index_o     <= set_q;
      tag_value_o     <= tag_q;
      old_tag_o       <= sel_v ? sel.tag : 32'd0;
      old_valid_o     <= sel_v;
      old_dirty_o     <= sel_dirty;
      prev_op_index_o <= sel_v ? sel.last_op : 32'd0;
      op_index_o      <= opc_q;
      access_cycles_o <= cost;
    end
  end

  assign out_valid_o = out_valid_q;

  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("accepted item while result pending");
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_wr |=> out_valid_o) else $error("write-back without result");
  a_opc_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_wr |=> opc_q == $past(opc_q) + 32'd1) else $error("op counter slip");
endmodule
